>>> rtl/abff_pkg.sv
// ----------------------------------------------------------------------------
// abff_pkg
// Shared types and constants for the allocation bitmap with first-free
// tracking: operation codes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package abff_pkg;

   // field widths
   localparam int KIND_W  = 3;
   localparam int ENTRY_W = 16;
   localparam int ITEM_W  = 8;
   localparam int COUNT_W = 9;
   localparam int CFG_W   = 9;

   // bitmap geometry: item indexes are 8 bits, so at most 256 items are reachable
   localparam int MAX_ITEMS   = 256;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_OFF_W = 4;
   localparam int GROUP_IDX_W = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 9'd511;
   localparam logic [2:0]         BIT_IN_BYTE = 3'h7;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_BYTE   = 3'd0,
      KIND_LOAD_COUNT  = 3'd1,
      KIND_MARK_FREE   = 3'd2,
      KIND_MARK_ALLOC  = 3'd3,
      KIND_QUERY       = 3'd4,
      KIND_ALLOC_FIRST = 3'd5
   } kind_type;

   typedef enum logic [0:0] {
      CSR_ITEMS_PER_ENTRY = 1'b0,
      CSR_VALID_ITEMS     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_LO,
      ST_SCAN_HI,
      ST_EXEC,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // latch the request
      logic scan_lo;  // run first encoder stage
      logic scan_hi;  // run second encoder stage
      logic exec;     // apply the operation
      logic finish;   // commit first-free, present result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic rescan;   // operation changes the bitmap
   } status_type;

endpackage

>>> rtl/abff_ctrl.sv
// ----------------------------------------------------------------------------
// abff_ctrl
// Operation sequencer: accept, encode the bitmap, execute, re-encode when the
// bitmap changed, then strobe the result for one cycle.
// ----------------------------------------------------------------------------
module abff_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output abff_pkg::cmd_type   cmd,
   input  abff_pkg::status_type status
);
   import abff_pkg::*;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cmd          = '0;
      rsp_valid_in = (state_ff == ST_DONE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               pass_in    = 1'b0;
               state_in   = ST_SCAN_LO;
            end
         end
         ST_SCAN_LO: begin
            cmd.scan_lo = 1'b1;
            state_in    = ST_SCAN_HI;
         end
         ST_SCAN_HI: begin
            cmd.scan_hi = 1'b1;
            state_in    = pass_ff ? ST_DONE : ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.rescan) begin
               pass_in  = 1'b1;
               state_in = ST_SCAN_LO;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // strobe follows the commit cycle
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid_ff)
      else $error("result strobe missing after commit");

   // strobe only while idle, never twice in a row
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE && !$past(rsp_valid_ff))
      else $error("result strobe outside idle or repeated");

   // a transfer starts the encoder
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == ST_SCAN_LO)
      else $error("accepted request did not start a scan");

   // encoder stages run back to back
   a_scan_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_LO |=> state_ff == ST_SCAN_HI)
      else $error("encoder stages split");

endmodule

>>> rtl/abff_datapath.sv
// ----------------------------------------------------------------------------
// abff_datapath
// Bitmap, free count, first-free register, configuration registers, a
// two-stage registered priority encoder and the operation logic.
// ----------------------------------------------------------------------------
module abff_datapath #(
   parameter int ENTRY_BITS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  abff_pkg::cmd_type                   cmd,
   output abff_pkg::status_type                status,
   input  logic [abff_pkg::KIND_W-1:0]         req_kind,
   input  logic [abff_pkg::ITEM_W-1:0]         req_item_index,
   input  logic [abff_pkg::COUNT_W-1:0]        req_load_value,
   input  logic                                csr_write,
   input  abff_pkg::csr_index_type             csr_index,
   input  logic [abff_pkg::CFG_W-1:0]          csr_data,
   output logic                                rsp_error,
   output logic                                rsp_item_allocated,
   output logic [abff_pkg::ITEM_W-1:0]         rsp_allocated_item,
   output logic [abff_pkg::COUNT_W-1:0]        rsp_free_count,
   output logic [abff_pkg::ITEM_W-1:0]         rsp_first_free
);
   import abff_pkg::*;

   // only the first 256 bits are reachable by an 8-bit item index
   localparam int STORE_BITS = (ENTRY_BITS < MAX_ITEMS) ? ENTRY_BITS : MAX_ITEMS;
   localparam int NUM_GROUPS = (STORE_BITS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_BITS   = NUM_GROUPS * GROUP_SIZE;
   localparam logic [COUNT_W-1:0] STORE_LIMIT = COUNT_W'(STORE_BITS);

   // lowest set bit of one group
   function automatic logic [GROUP_OFF_W-1:0] low_bit(input logic [GROUP_SIZE-1:0] v);
      logic [GROUP_OFF_W-1:0] r;
      r = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
         if (v[j]) r = GROUP_OFF_W'(j);
      end
      return r;
   endfunction

   // request latch
   logic [KIND_W-1:0]  kind_ff;
   logic [ITEM_W-1:0]  item_ff;
   logic [COUNT_W-1:0] load_ff;

   // configuration
   logic [CFG_W-1:0]   items_per_entry_ff, items_per_entry_in;
   logic [CFG_W-1:0]   valid_items_ff, valid_items_in;

   // architectural state
   logic [STORE_BITS-1:0] bits_ff, bits_in;
   logic [COUNT_W-1:0]    free_total_ff, free_total_in;
   logic [ITEM_W-1:0]     lowest_ff, lowest_in;

   // encoder pipeline
   logic [NUM_GROUPS-1:0]                  grp_any_ff, grp_any_in;
   logic [NUM_GROUPS-1:0][GROUP_OFF_W-1:0] grp_off_ff, grp_off_in;
   logic                                   found_ff, found_in;
   logic [ITEM_W-1:0]                      pos_ff, pos_in;

   // result
   logic              error_ff, error_in;
   logic              qres_ff, qres_in;
   logic [ITEM_W-1:0] taken_ff, taken_in;
   logic              changed_ff, changed_in;

   // operation helpers
   logic [MAX_ITEMS-1:0]  bits_ext;
   logic [MAX_ITEMS-1:0]  bits_next;
   logic [STORE_BITS-1:0] masked;
   logic [PAD_BITS-1:0]   scan_vec;
   logic                  bit_cur;
   logic                  item_ok;
   logic [ITEM_W-1:0]     byte_base;
   logic                  byte_ok;
   logic [COUNT_W-1:0]    count_up;
   logic [COUNT_W-1:0]    count_down;
   logic                  op_err, op_qres, op_change;
   logic [ITEM_W-1:0]     op_taken;
   logic [COUNT_W-1:0]    op_total;

   assign bits_ext = MAX_ITEMS'(bits_ff);

   // first encoder stage: mask to the scan limit, encode each group
   always_comb begin
      for (int i = 0; i < STORE_BITS; i++) begin
         masked[i] = bits_ff[i] & (COUNT_W'(i) < valid_items_ff);
      end
      scan_vec = PAD_BITS'(masked);
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |scan_vec[g*GROUP_SIZE +: GROUP_SIZE];
         grp_off_in[g] = low_bit(scan_vec[g*GROUP_SIZE +: GROUP_SIZE]);
      end
   end

   // second encoder stage: pick the lowest non-empty group
   always_comb begin
      found_in = |grp_any_ff;
      pos_in   = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) pos_in = {GROUP_IDX_W'(g), grp_off_ff[g]};
      end
   end

   // operation logic
   always_comb begin
      bit_cur    = bits_ext[item_ff];
      item_ok    = ({1'b0, item_ff} < items_per_entry_ff) && ({1'b0, item_ff} < STORE_LIMIT);
      byte_base  = item_ff & ~{{(ITEM_W-3){1'b0}}, BIT_IN_BYTE};
      byte_ok    = {1'b0, byte_base} < STORE_LIMIT;
      count_up   = (free_total_ff == COUNT_MAX) ? free_total_ff : free_total_ff + 1'b1;
      count_down = (free_total_ff == '0) ? free_total_ff : free_total_ff - 1'b1;

      bits_next = bits_ext;
      op_err    = 1'b0;
      op_qres   = 1'b0;
      op_taken  = '0;
      op_total  = free_total_ff;
      op_change = 1'b0;
      case (kind_type'(kind_ff))
         KIND_LOAD_BYTE: begin
            if (!byte_ok) begin
               op_err = 1'b1;
            end else begin
               // bits past the stored width drop out on the truncation below
               for (int b = 0; b < 8; b++) begin
                  bits_next[byte_base | {{(ITEM_W-3){1'b0}}, 3'(b)}] = load_ff[b];
               end
               op_change = 1'b1;
            end
         end
         KIND_LOAD_COUNT: begin
            op_total = load_ff;
         end
         KIND_MARK_FREE: begin
            if (!item_ok || bit_cur) begin
               op_err = 1'b1;
            end else begin
               bits_next[item_ff] = 1'b1;
               op_total  = count_up;
               op_change = 1'b1;
            end
         end
         KIND_MARK_ALLOC: begin
            if (!item_ok || !bit_cur) begin
               op_err = 1'b1;
            end else begin
               bits_next[item_ff] = 1'b0;
               op_total  = count_down;
               op_change = 1'b1;
            end
         end
         KIND_QUERY: begin
            if (!item_ok) begin
               op_err = 1'b1;
            end else begin
               op_qres = ~bit_cur;
            end
         end
         KIND_ALLOC_FIRST: begin
            if (!found_ff) begin
               op_err = 1'b1;
            end else begin
               bits_next[pos_ff] = 1'b0;
               op_taken  = pos_ff;
               op_total  = count_down;
               op_change = 1'b1;
            end
         end
         default: begin
            op_err = 1'b1;
         end
      endcase
   end

   assign status.rescan = op_change;

   // next values of the state registers
   always_comb begin
      items_per_entry_in = items_per_entry_ff;
      valid_items_in     = valid_items_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ITEMS_PER_ENTRY: items_per_entry_in = csr_data;
            CSR_VALID_ITEMS:     valid_items_in     = csr_data;
            default:             items_per_entry_in = items_per_entry_ff;
         endcase
      end

      bits_in       = cmd.exec ? bits_next[STORE_BITS-1:0] : bits_ff;
      free_total_in = cmd.exec ? op_total : free_total_ff;
      error_in      = cmd.exec ? op_err : error_ff;
      qres_in       = cmd.exec ? op_qres : qres_ff;
      taken_in      = cmd.exec ? op_taken : taken_ff;
      changed_in    = cmd.exec ? op_change : changed_ff;

      // first-free is recomputed only after a change
      lowest_in = lowest_ff;
      if (cmd.finish && changed_ff) begin
         lowest_in = found_ff ? pos_ff : '0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         items_per_entry_ff <= CFG_W'(MAX_ITEMS);
         valid_items_ff     <= CFG_W'(MAX_ITEMS);
         bits_ff            <= '0;
         free_total_ff      <= '0;
         lowest_ff          <= '0;
      end else begin
         items_per_entry_ff <= items_per_entry_in;
         valid_items_ff     <= valid_items_in;
         bits_ff            <= bits_in;
         free_total_ff      <= free_total_in;
         lowest_ff          <= lowest_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         item_ff <= req_item_index;
         load_ff <= req_load_value;
      end
      if (cmd.scan_lo) begin
         grp_any_ff <= grp_any_in;
         grp_off_ff <= grp_off_in;
      end
      if (cmd.scan_hi) begin
         found_ff <= found_in;
         pos_ff   <= pos_in;
      end
      error_ff   <= error_in;
      qres_ff    <= qres_in;
      taken_ff   <= taken_in;
      changed_ff <= changed_in;
   end

   assign rsp_error          = error_ff;
   assign rsp_item_allocated = qres_ff;
   assign rsp_allocated_item = taken_ff;
   assign rsp_free_count     = free_total_ff;
   assign rsp_first_free     = lowest_ff;

   // a successful allocate takes a free bit and clears it
   a_alloc_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && kind_ff == KIND_ALLOC_FIRST && found_ff
      |=> !bits_ext[$past(pos_ff)] && taken_ff == $past(pos_ff))
      else $error("allocate did not clear the chosen bit");

   // bitmap moves only on execute
   a_bits_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec && !$past(reset) |=> $stable(bits_ff) || $past(cmd.exec))
      else $error("bitmap changed outside execute");

   // a change always updates first-free from the fresh encode
   a_lowest_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && changed_ff |=> lowest_ff == ($past(found_ff) ? $past(pos_ff) : '0))
      else $error("first-free not committed");

endmodule

>>> rtl/allocation_bitmap_first_free.sv
// ----------------------------------------------------------------------------
// allocation_bitmap_first_free
// Allocation bitmap for one entry (set bit = free item) with free count and
// lowest-free tracking; one operation per request, one result per request.
//
//   channel   handshake            payload
//   request   start / busy         req_kind, req_entry_number, req_item_index,
//                                  req_load_value
//   result    rsp_valid (1 cycle)  rsp_error, rsp_item_allocated,
//                                  rsp_allocated_item, rsp_free_count,
//                                  rsp_first_free
//   config    csr_valid / csr_ready csr_index, csr_data
//
// An operation runs the two-stage registered priority encoder over the bitmap
// once before execute and again after a change, then commits and raises
// rsp_valid. The next request is taken in the rsp_valid cycle.
// Reset is synchronous; the bitmap clears at once, no clearing pass.
// The receiver cannot stall; csr_ready is always high.
// ----------------------------------------------------------------------------
module allocation_bitmap_first_free #(
   parameter int ENTRY_BITS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [abff_pkg::KIND_W-1:0]       req_kind,
   input  logic [abff_pkg::ENTRY_W-1:0]      req_entry_number,
   input  logic [abff_pkg::ITEM_W-1:0]       req_item_index,
   input  logic [abff_pkg::COUNT_W-1:0]      req_load_value,
   output logic                              rsp_valid,
   output logic                              rsp_error,
   output logic                              rsp_item_allocated,
   output logic [abff_pkg::ITEM_W-1:0]       rsp_allocated_item,
   output logic [abff_pkg::COUNT_W-1:0]      rsp_free_count,
   output logic [abff_pkg::ITEM_W-1:0]       rsp_first_free,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  abff_pkg::csr_index_type           csr_index,
   input  logic [abff_pkg::CFG_W-1:0]        csr_data
);
   import abff_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // req_entry_number cancels out of the bit position and is not used

   abff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   abff_datapath #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_item_index     (req_item_index),
      .req_load_value     (req_load_value),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_error          (rsp_error),
      .rsp_item_allocated (rsp_item_allocated),
      .rsp_allocated_item (rsp_allocated_item),
      .rsp_free_count     (rsp_free_count),
      .rsp_first_free     (rsp_first_free)
   );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for allocation_bitmap_first_free. A directed table runs
// first and covers the field extremes, every operation, count saturation,
// out-of-range items, a zero scan limit and stale first-free after register
// writes. Random phases follow, each under its own register setting and
// request idling. Every result is checked against its typed table row or a
// bit-accurate bitmap predictor tracking each accepted request and register write.
// ----------------------------------------------------------------------------
module testbench;
   import abff_pkg::*;

   localparam int NUM_BITS     = 256;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_GAP      = 40;

   // kind codes with no operation behind them
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                error;
      logic                item_allocated;
      logic [ITEM_W-1:0]   allocated_item;
      logic [COUNT_W-1:0]  free_count;
      logic [ITEM_W-1:0]   first_free;
   } op_status_type;

   typedef struct packed {
      bit                  csr_row;
      csr_index_type       csr_sel;
      logic [KIND_W-1:0]   kind;
      logic [ENTRY_W-1:0]  entry;
      logic [ITEM_W-1:0]   item;
      logic [COUNT_W-1:0]  value;
      bit                  typed;
      op_status_type       want;
   } step_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [KIND_W-1:0]    req_kind;
   logic [ENTRY_W-1:0]   req_entry_number;
   logic [ITEM_W-1:0]    req_item_index;
   logic [COUNT_W-1:0]   req_load_value;
   logic                 rsp_valid;
   logic                 rsp_error;
   logic                 rsp_item_allocated;
   logic [ITEM_W-1:0]    rsp_allocated_item;
   logic [COUNT_W-1:0]   rsp_free_count;
   logic [ITEM_W-1:0]    rsp_first_free;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [CFG_W-1:0]     csr_data;

   // predictor state
   bit   [NUM_BITS-1:0]  model_free_map;
   logic [COUNT_W-1:0]   model_free_total;
   logic [ITEM_W-1:0]    model_lowest_free;
   logic [CFG_W-1:0]     model_items_per_entry;
   logic [CFG_W-1:0]     model_valid_items;

   op_status_type        pending_status[$];
   int                   mismatches;
   int                   idle_pct;

   localparam int NUM_ROWS = 26;

   step_row_type directed_rows [0:NUM_ROWS-1] = '{
      // state right after reset
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_QUERY, 16'h0000, 8'd0, 9'd0,
        1'b1, '{1'b0, 1'b1, 8'd0, 9'd0, 8'd0}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_ALLOC_FIRST, 16'hFFFF, 8'd255, 9'd511,
        1'b1, '{1'b1, 1'b0, 8'd0, 9'd0, 8'd0}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_SPARE_LO, 16'h0000, 8'd0, 9'd0,
        1'b1, '{1'b1, 1'b0, 8'd0, 9'd0, 8'd0}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_SPARE_HI, 16'hFFFF, 8'd255, 9'd511,
        1'b1, '{1'b1, 1'b0, 8'd0, 9'd0, 8'd0}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_ALLOC, 16'h1234, 8'd255, 9'd0,
        1'b1, '{1'b1, 1'b0, 8'd0, 9'd0, 8'd0}},
      // count saturates at the top, double free is refused
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_LOAD_COUNT, 16'h0000, 8'd0, 9'd511,
        1'b1, '{1'b0, 1'b0, 8'd0, 9'd511, 8'd0}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_FREE, 16'hFFFF, 8'd255, 9'd0,
        1'b1, '{1'b0, 1'b0, 8'd0, 9'd511, 8'd255}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_FREE, 16'h0001, 8'd255, 9'd0,
        1'b1, '{1'b1, 1'b0, 8'd0, 9'd511, 8'd255}},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_QUERY, 16'h8000, 8'd255, 9'd0,
        1'b1, '{1'b0, 1'b0, 8'd0, 9'd511, 8'd255}},
      // byte loads (bit 8 of the value ignored), allocation, count floor
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_LOAD_BYTE, 16'h00FF, 8'd7, 9'h1A0,
        1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_LOAD_BYTE, 16'hFF00, 8'd248, 9'h0FF,
        1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_QUERY, 16'h0000, 8'd5, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_ALLOC_FIRST, 16'h0000, 8'd0, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_ALLOC, 16'h0000, 8'd7, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_LOAD_COUNT, 16'h0000, 8'd0, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_ALLOC, 16'h0000, 8'd255, 9'd0, 1'b0, '0},
      // no item in range
      '{1'b1, CSR_ITEMS_PER_ENTRY, KIND_LOAD_BYTE, 16'h0000, 8'd0, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_QUERY, 16'h0000, 8'd0, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_FREE, 16'h0000, 8'd1, 9'd0, 1'b0, '0},
      '{1'b1, CSR_ITEMS_PER_ENTRY, KIND_LOAD_BYTE, 16'h0000, 8'd0, 9'd256, 1'b0, '0},
      // empty scan window, then first-free left stale by the register write
      '{1'b1, CSR_VALID_ITEMS, KIND_LOAD_BYTE, 16'h0000, 8'd0, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_MARK_FREE, 16'h0000, 8'd3, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_ALLOC_FIRST, 16'h0000, 8'd0, 9'd0, 1'b0, '0},
      '{1'b1, CSR_VALID_ITEMS, KIND_LOAD_BYTE, 16'h0000, 8'd0, 9'd256, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_QUERY, 16'h0000, 8'd3, 9'd0, 1'b0, '0},
      '{1'b0, CSR_ITEMS_PER_ENTRY, KIND_ALLOC_FIRST, 16'h0000, 8'd0, 9'd0, 1'b0, '0}
   };

   allocation_bitmap_first_free dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_entry_number   (req_entry_number),
      .req_item_index     (req_item_index),
      .req_load_value     (req_load_value),
      .rsp_valid          (rsp_valid),
      .rsp_error          (rsp_error),
      .rsp_item_allocated (rsp_item_allocated),
      .rsp_allocated_item (rsp_allocated_item),
      .rsp_free_count     (rsp_free_count),
      .rsp_first_free     (rsp_first_free),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // priority encode over the scan window; returns 0 when nothing is free
   function automatic bit lowest_free_item(output logic [ITEM_W-1:0] pos);
      int limit;
      limit = (model_valid_items > NUM_BITS) ? NUM_BITS : int'(model_valid_items);
      pos = '0;
      for (int i = 0; i < limit; i++) begin
         if (model_free_map[i]) begin
            pos = ITEM_W'(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // apply one operation to the bitmap and return the status it reports
   function automatic op_status_type predict_status(input logic [KIND_W-1:0] kind,
                                                    input logic [ITEM_W-1:0] item,
                                                    input logic [COUNT_W-1:0] value);
      op_status_type     st;
      logic [ITEM_W-1:0] pos;
      bit                in_range;
      st = '0;
      in_range = (item < model_items_per_entry);
      case (kind)
         KIND_LOAD_BYTE: begin
            model_free_map[{item[ITEM_W-1:3], 3'b000} +: 8] = value[7:0];
            void'(lowest_free_item(model_lowest_free));
         end
         KIND_LOAD_COUNT: begin
            model_free_total = value;
         end
         KIND_MARK_FREE: begin
            if (!in_range || model_free_map[item]) begin
               st.error = 1'b1;
            end else begin
               model_free_map[item] = 1'b1;
               if (model_free_total != COUNT_MAX)
                  model_free_total = model_free_total + 1'b1;
               void'(lowest_free_item(model_lowest_free));
            end
         end
         KIND_MARK_ALLOC: begin
            if (!in_range || !model_free_map[item]) begin
               st.error = 1'b1;
            end else begin
               model_free_map[item] = 1'b0;
               if (model_free_total != '0)
                  model_free_total = model_free_total - 1'b1;
               void'(lowest_free_item(model_lowest_free));
            end
         end
         KIND_QUERY: begin
            if (!in_range)
               st.error = 1'b1;
            else
               st.item_allocated = !model_free_map[item];
         end
         KIND_ALLOC_FIRST: begin
            if (!lowest_free_item(pos)) begin
               st.error = 1'b1;
            end else begin
               model_free_map[pos] = 1'b0;
               st.allocated_item = pos;
               if (model_free_total != '0)
                  model_free_total = model_free_total - 1'b1;
               void'(lowest_free_item(model_lowest_free));
            end
         end
         default: begin
            st.error = 1'b1;
         end
      endcase
      st.free_count = model_free_total;
      st.first_free = model_lowest_free;
      return st;
   endfunction

   function automatic string status_text(input op_status_type s);
      return $sformatf("error=%0d allocated=%0d taken=%0d count=%0d first=%0d",
                       s.error, s.item_allocated, s.allocated_item,
                       s.free_count, s.first_free);
   endfunction

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] %s", $realtime, msg);
   endfunction

   // compare each result transfer with the oldest pending status
   always @(posedge clock) begin
      op_status_type got;
      op_status_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_error, rsp_item_allocated, rsp_allocated_item,
                rsp_free_count, rsp_first_free};
         if (pending_status.size() == 0) begin
            note_failure({"unexpected result: ", status_text(got)});
         end else begin
            want = pending_status.pop_front();
            if (got !== want)
               note_failure({"mismatch: expected ", status_text(want),
                             " / actual ", status_text(got)});
         end
      end
   end

   // present one request after a random idle gap; predict it on transfer
   task automatic send_op(input logic [KIND_W-1:0] kind,
                          input logic [ENTRY_W-1:0] entry,
                          input logic [ITEM_W-1:0] item,
                          input logic [COUNT_W-1:0] value,
                          input bit typed,
                          input op_status_type want);
      op_status_type predicted;
      int            gap;
      gap = 0;
      while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         gap++;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_kind         <= kind;
      req_entry_number <= entry;
      req_item_index   <= item;
      req_load_value   <= value;
      do @(posedge clock); while (busy);
      predicted = predict_status(kind, item, value);
      pending_status.push_back(typed ? want : predicted);
   endtask

   // drop start and hold until every pending result has arrived
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (sel == CSR_ITEMS_PER_ENTRY)
         model_items_per_entry = data;
      else
         model_valid_items = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed operations on items in range, some noise
   task automatic send_random_op();
      logic [KIND_W-1:0]  kind;
      logic [ITEM_W-1:0]  item;
      logic [COUNT_W-1:0] value;
      int                 span;
      int                 roll;
      roll = $urandom_range(0, 99);
      if (model_items_per_entry == 0 || model_items_per_entry > NUM_BITS)
         span = NUM_BITS;
      else
         span = int'(model_items_per_entry);
      if (roll < 8)
         kind = KIND_LOAD_BYTE;
      else if (roll < 12)
         kind = KIND_LOAD_COUNT;
      else if (roll < 37)
         kind = KIND_MARK_FREE;
      else if (roll < 57)
         kind = KIND_MARK_ALLOC;
      else if (roll < 72)
         kind = KIND_QUERY;
      else if (roll < 95)
         kind = KIND_ALLOC_FIRST;
      else
         kind = roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
      if ($urandom_range(0, 9) == 0)
         item = ITEM_W'($urandom_range(0, 255));
      else
         item = ITEM_W'($urandom_range(0, span - 1));
      // prefer an item whose state lets the mark go through
      for (int t = 0; t < 3 && ((kind == KIND_MARK_FREE && model_free_map[item]) ||
                                (kind == KIND_MARK_ALLOC && !model_free_map[item])); t++)
         item = ITEM_W'($urandom_range(0, span - 1));
      value = COUNT_W'($urandom_range(0, 511));
      send_op(kind, ENTRY_W'($urandom_range(0, 65535)), item, value, 1'b0, '0);
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] items_cfg,
                            input logic [CFG_W-1:0] valid_cfg,
                            input int pct,
                            input int count);
      wait_drained();
      write_csr(CSR_ITEMS_PER_ENTRY, items_cfg);
      write_csr(CSR_VALID_ITEMS, valid_cfg);
      idle_pct = pct;
      for (int n = 0; n < count; n++) begin
         // now and then let the pipe run empty
         if ($urandom_range(0, 49) == 0)
            wait_drained();
         send_random_op();
      end
   endtask

   initial begin
      reset                 = 1'b1;
      start                 = 1'b0;
      req_kind              = KIND_LOAD_BYTE;
      req_entry_number      = '0;
      req_item_index        = '0;
      req_load_value        = '0;
      csr_valid             = 1'b0;
      csr_index             = CSR_ITEMS_PER_ENTRY;
      csr_data              = '0;
      model_free_map        = '0;
      model_free_total      = '0;
      model_lowest_free     = '0;
      model_items_per_entry = 9'd256;
      model_valid_items     = 9'd256;
      mismatches            = 0;
      idle_pct              = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr_row) begin
            wait_drained();
            write_csr(directed_rows[r].csr_sel, directed_rows[r].value);
         end else begin
            send_op(directed_rows[r].kind, directed_rows[r].entry,
                    directed_rows[r].item, directed_rows[r].value,
                    directed_rows[r].typed, directed_rows[r].want);
         end
      end

      // random phases: register setting, idle percentage, request count
      run_phase(9'd256, 9'd256, 0, 300);
      run_phase(9'd1, 9'd256, 86, 150);
      run_phase(9'd256, 9'd0, 0, 150);
      run_phase(9'd100, 9'd37, 18, 200);
      run_phase(9'd0, 9'd511, 86, 100);
      run_phase(9'd8, 9'd8, 0, 200);
      run_phase(9'd256, 9'd256, 18, 300);
      run_phase(9'd200, 9'd256, 86, 150);
      run_phase(CFG_W'($urandom_range(1, 256)), CFG_W'($urandom_range(0, 256)), 18, 200);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
